// ===== sv/lcl_pkg.sv =====
`default_nettype none
package lcl_pkg;

  localparam int unsigned WORD_W   = 31;
  localparam int unsigned WIDE_W   = 64;
  localparam int unsigned SIGN_W   = 33;
  localparam int unsigned IN_TD_W  = 128;
  localparam int unsigned OUT_TD_W = 64;
  localparam int unsigned CNT_W    = 7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FM_START,
    OP_RHS_START,
    OP_GCD_INIT,
    OP_GCD_DIV,
    OP_GCD_STEP,
    OP_QR_START,
    OP_S_START,
    OP_S_TAKE,
    OP_RES_ZERO,
    OP_RES_ONE,
    OP_W_START,
    OP_A_START,
    OP_INV_INIT,
    OP_INV_DIV,
    OP_INV_MUL,
    OP_INV_SUB,
    OP_FIN_MUL,
    OP_FIN_DIV,
    OP_RES_OFF,
    OP_PUSH
  } op_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic m_zero;
    logic b_zero;
    logic s_one;
    logic r1_zero;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/linear_congruence_lane_offset.sv =====
`default_nettype none
// Channel  Dir  Fields (low bit up)
// in_      in   filter_modulus[30:0], filter_residue[61:31], lane_start[125:62]
// out_     out  hit_offset[30:0], hit_step[61:31]
// cfg_     in   wheel_modulus at byte address 0
//
// One item at a time. The gcd and the modular inverse are Euclid loops, and
// all division goes through one radix-2 divider, with a 64-bit dividend or a
// 32-bit one. A zero modulus skips the division and gives a zero result.
// Reset clears the controller and sets wheel_modulus to 1.
// A finished result waits in the output register while the next beat runs;
// input is held off while a second result waits for that register.
module linear_congruence_lane_offset (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // filter_modulus, filter_residue, lane_start, zero pad
  input  wire logic [127:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // hit_offset, hit_step, zero pad
  output logic      [63:0]   out_tdata,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready
);

  logic [lcl_pkg::WORD_W-1:0] wheel_r;
  lcl_pkg::op_t               op;
  lcl_pkg::status_t           status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r <= lcl_pkg::WORD_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      wheel_r <= cfg_pwdata[lcl_pkg::WORD_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'b0 : {1'b0, wheel_r};

  lcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .op        (op)
  );

  lcl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .wheel    (wheel_r),
    .in_data  (in_tdata),
    .out_data (out_tdata),
    .status   (status)
  );

endmodule
`default_nettype wire

// ===== sv/lcl_div.sv =====
`default_nettype none
module lcl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        short_op,
  input  wire logic [lcl_pkg::WIDE_W-1:0]  dvd,
  input  wire logic [lcl_pkg::WORD_W-1:0]  dvs,
  output logic                             done,
  output logic      [lcl_pkg::WIDE_W-1:0]  quo,
  output logic      [lcl_pkg::WORD_W-1:0]  rem
);

  logic                        busy_r, done_r;
  logic [lcl_pkg::CNT_W-1:0]   cnt_r;
  logic [lcl_pkg::WIDE_W-1:0]  dvd_r, quo_r;
  logic [lcl_pkg::WORD_W-1:0]  dvs_r, rem_r;
  logic [lcl_pkg::WORD_W:0]    shifted, diff;
  logic                        ge;

  assign shifted = {rem_r, dvd_r[lcl_pkg::WIDE_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == lcl_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= short_op ? {dvd[31:0], 32'b0} : dvd;
      dvs_r <= dvs;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= short_op ? lcl_pkg::CNT_W'(32) : lcl_pkg::CNT_W'(64);
    end else if (busy_r) begin
      rem_r <= ge ? diff[lcl_pkg::WORD_W-1:0] : shifted[lcl_pkg::WORD_W-1:0];
      dvd_r <= {dvd_r[lcl_pkg::WIDE_W-2:0], 1'b0};
      quo_r <= {quo_r[lcl_pkg::WIDE_W-2:0], ge};
      cnt_r <= cnt_r - lcl_pkg::CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== sv/lcl_dp.sv =====
`default_nettype none
module lcl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lcl_pkg::op_t                  op,
  input  wire logic [lcl_pkg::WORD_W-1:0]    wheel,
  input  wire logic [lcl_pkg::IN_TD_W-1:0]   in_data,
  output logic      [lcl_pkg::OUT_TD_W-1:0]  out_data,
  output lcl_pkg::status_t                   status
);

  logic [lcl_pkg::WORD_W-1:0]        m_r, res_r, a_r, b_r, qr_r, s_r, r0_r, r1_r;
  logic [lcl_pkg::WORD_W-1:0]        off_r, step_r, oo_r, os_r;
  logic [lcl_pkg::WIDE_W-1:0]        first_r;
  logic [31:0]                       rhs_r, rhs_raw;
  logic signed [lcl_pkg::SIGN_W-1:0] t0_r, t1_r, tpos, mul_a, mul_b;
  logic signed [2*lcl_pkg::SIGN_W-1:0] mul_p;
  logic [lcl_pkg::WIDE_W-1:0]        prod_r;

  logic                        div_start, div_short, div_done;
  logic [lcl_pkg::WIDE_W-1:0]  div_dvd, div_quo;
  logic [lcl_pkg::WORD_W-1:0]  div_dvs, div_rem;

  lcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .short_op (div_short),
    .dvd      (div_dvd),
    .dvs      (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign rhs_raw = {1'b0, res_r} + {1'b0, m_r} - {1'b0, div_rem};
  assign tpos    = t0_r[lcl_pkg::SIGN_W-1] ? t0_r + {2'b0, s_r} : t0_r;
  assign mul_p   = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_short = 1'b1;
    div_dvd   = '0;
    div_dvs   = m_r;
    mul_a     = {2'b0, qr_r};
    mul_b     = {2'b0, tpos[lcl_pkg::WORD_W-1:0]};
    case (op)
      lcl_pkg::OP_FM_START: begin
        div_start = 1'b1;
        div_short = 1'b0;
        div_dvd   = first_r;
      end
      lcl_pkg::OP_RHS_START: begin
        div_start = 1'b1;
        div_dvd   = {32'b0, rhs_raw};
      end
      lcl_pkg::OP_GCD_DIV: begin
        div_start = 1'b1;
        div_dvd   = {33'b0, a_r};
        div_dvs   = b_r;
      end
      lcl_pkg::OP_QR_START: begin
        div_start = 1'b1;
        div_dvd   = {32'b0, rhs_r};
        div_dvs   = a_r;
      end
      lcl_pkg::OP_S_START: begin
        div_start = 1'b1;
        div_dvd   = {33'b0, m_r};
        div_dvs   = a_r;
      end
      lcl_pkg::OP_W_START: begin
        div_start = 1'b1;
        div_dvd   = {33'b0, wheel};
        div_dvs   = a_r;
      end
      lcl_pkg::OP_A_START: begin
        div_start = 1'b1;
        div_dvd   = {33'b0, div_quo[lcl_pkg::WORD_W-1:0]};
        div_dvs   = s_r;
      end
      lcl_pkg::OP_INV_DIV: begin
        div_start = 1'b1;
        div_dvd   = {33'b0, r0_r};
        div_dvs   = r1_r;
      end
      lcl_pkg::OP_INV_MUL: begin
        mul_a = {2'b0, div_quo[lcl_pkg::WORD_W-1:0]};
        mul_b = t1_r;
      end
      lcl_pkg::OP_FIN_DIV: begin
        div_start = 1'b1;
        div_short = 1'b0;
        div_dvd   = prod_r;
        div_dvs   = s_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      lcl_pkg::OP_LOAD: begin
        m_r     <= in_data[30:0];
        res_r   <= in_data[61:31];
        first_r <= in_data[125:62];
      end
      lcl_pkg::OP_GCD_INIT: begin
        rhs_r <= {1'b0, div_rem};
        a_r   <= wheel;
        b_r   <= m_r;
      end
      lcl_pkg::OP_GCD_STEP: begin
        a_r <= b_r;
        b_r <= div_rem;
      end
      lcl_pkg::OP_S_START: qr_r <= div_quo[lcl_pkg::WORD_W-1:0];
      lcl_pkg::OP_S_TAKE:  s_r  <= div_quo[lcl_pkg::WORD_W-1:0];
      lcl_pkg::OP_RES_ZERO: begin
        off_r  <= '0;
        step_r <= '0;
      end
      lcl_pkg::OP_RES_ONE: begin
        off_r  <= '0;
        step_r <= s_r;
      end
      lcl_pkg::OP_INV_INIT: begin
        r0_r <= s_r;
        r1_r <= div_rem;
        t0_r <= '0;
        t1_r <= lcl_pkg::SIGN_W'(1);
      end
      lcl_pkg::OP_INV_MUL: begin
        prod_r <= mul_p[lcl_pkg::WIDE_W-1:0];
        r0_r   <= r1_r;
        r1_r   <= div_rem;
      end
      lcl_pkg::OP_INV_SUB: begin
        t0_r <= t1_r;
        t1_r <= t0_r - $signed(prod_r[lcl_pkg::SIGN_W-1:0]);
      end
      lcl_pkg::OP_FIN_MUL: prod_r <= mul_p[lcl_pkg::WIDE_W-1:0];
      lcl_pkg::OP_RES_OFF: begin
        off_r  <= div_rem;
        step_r <= s_r;
      end
      lcl_pkg::OP_PUSH: begin
        oo_r <= off_r;
        os_r <= step_r;
      end
      default: begin
      end
    endcase
  end

  assign out_data        = {2'b0, os_r, oo_r};
  assign status.div_done = div_done;
  assign status.rem_zero = div_rem == '0;
  assign status.m_zero   = m_r == '0;
  assign status.b_zero   = b_r == '0;
  assign status.s_one    = s_r == lcl_pkg::WORD_W'(1);
  assign status.r1_zero  = r1_r == '0;

endmodule
`default_nettype wire

// ===== sv/lcl_ctrl.sv =====
`default_nettype none
module lcl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lcl_pkg::status_t  status,
  output lcl_pkg::op_t           op
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_CHK  = 18'h00002,
    S_FM   = 18'h00004,
    S_RHS  = 18'h00008,
    S_GCHK = 18'h00010,
    S_GDIV = 18'h00020,
    S_QR   = 18'h00040,
    S_S    = 18'h00080,
    S_S1   = 18'h00100,
    S_W    = 18'h00200,
    S_A    = 18'h00400,
    S_ICHK = 18'h00800,
    S_IDIV = 18'h01000,
    S_ISUB = 18'h02000,
    S_FMUL = 18'h04000,
    S_FDIV = 18'h08000,
    S_OUT  = 18'h10000,
    S_SPR  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = lcl_pkg::OP_NONE;
    ov_nxt    = ov_r & ~out_ready;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op        = lcl_pkg::OP_LOAD;
        state_nxt = S_CHK;
      end
      S_CHK: if (status.m_zero) begin
        op        = lcl_pkg::OP_RES_ZERO;
        state_nxt = S_OUT;
      end else begin
        op        = lcl_pkg::OP_FM_START;
        state_nxt = S_FM;
      end
      S_FM: if (status.div_done) begin
        op        = lcl_pkg::OP_RHS_START;
        state_nxt = S_RHS;
      end
      S_RHS: if (status.div_done) begin
        op        = lcl_pkg::OP_GCD_INIT;
        state_nxt = S_GCHK;
      end
      S_GCHK: if (status.b_zero) begin
        op        = lcl_pkg::OP_QR_START;
        state_nxt = S_QR;
      end else begin
        op        = lcl_pkg::OP_GCD_DIV;
        state_nxt = S_GDIV;
      end
      S_GDIV: if (status.div_done) begin
        op        = lcl_pkg::OP_GCD_STEP;
        state_nxt = S_GCHK;
      end
      S_QR: if (status.div_done) begin
        if (status.rem_zero) begin
          op        = lcl_pkg::OP_S_START;
          state_nxt = S_S;
        end else begin
          op        = lcl_pkg::OP_RES_ZERO;
          state_nxt = S_OUT;
        end
      end
      S_S: if (status.div_done) begin
        op        = lcl_pkg::OP_S_TAKE;
        state_nxt = S_S1;
      end
      S_S1: if (status.s_one) begin
        op        = lcl_pkg::OP_RES_ONE;
        state_nxt = S_OUT;
      end else begin
        op        = lcl_pkg::OP_W_START;
        state_nxt = S_W;
      end
      S_W: if (status.div_done) begin
        op        = lcl_pkg::OP_A_START;
        state_nxt = S_A;
      end
      S_A: if (status.div_done) begin
        op        = lcl_pkg::OP_INV_INIT;
        state_nxt = S_ICHK;
      end
      S_ICHK: if (status.r1_zero) begin
        op        = lcl_pkg::OP_FIN_MUL;
        state_nxt = S_FMUL;
      end else begin
        op        = lcl_pkg::OP_INV_DIV;
        state_nxt = S_IDIV;
      end
      S_IDIV: if (status.div_done) begin
        op        = lcl_pkg::OP_INV_MUL;
        state_nxt = S_ISUB;
      end
      S_ISUB: begin
        op        = lcl_pkg::OP_INV_SUB;
        state_nxt = S_ICHK;
      end
      S_FMUL: begin
        op        = lcl_pkg::OP_FIN_DIV;
        state_nxt = S_FDIV;
      end
      S_FDIV: if (status.div_done) begin
        op        = lcl_pkg::OP_RES_OFF;
        state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || out_ready) begin
        op        = lcl_pkg::OP_PUSH;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SPR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ov_r;

endmodule
`default_nettype wire

// ===== tb/sv/lane_offset_checker.sv =====
`default_nettype none
module lane_offset_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tready,
  input  wire logic [127:0]  in_tdata,
  input  wire logic          out_tvalid,
  input  wire logic          out_tready,
  input  wire logic [63:0]   out_tdata,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  input  wire logic          cfg_pready,
  output int                 fail_count,
  output int                 pending,
  output int                 solved_count,
  output int                 miss_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] WHEEL_ADDR = 3'd0;

  typedef struct packed {
    logic [lcl_pkg::WORD_W-1:0] offset;
    logic [lcl_pkg::WORD_W-1:0] step;
  } hit_t;

  logic [lcl_pkg::WORD_W-1:0] wheel;
  hit_t hits_due[$];

  function automatic hit_t solve_lane(logic [lcl_pkg::WORD_W-1:0] w,
                                      logic [lcl_pkg::WORD_W-1:0] m,
                                      logic [lcl_pkg::WORD_W-1:0] r,
                                      logic [lcl_pkg::WIDE_W-1:0] f);
    longint unsigned a, b, t, g, rhs, s, aa, qq;
    longint r0, r1, t0, t1, q, nr, nt;
    hit_t h;
    h = '0;
    if (m == 0) return h;
    a = w;
    b = m;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    g = a;
    rhs = (longint'(r) + m - (f % m)) % m;
    if (rhs % g != 0) return h;
    s = m / g;
    h.step = lcl_pkg::WORD_W'(s);
    if (s == 1) return h;
    aa = (w / g) % s;
    r0 = s;
    r1 = aa;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    t0 = t0 % longint'(s);
    if (t0 < 0) t0 += longint'(s);
    qq = ((rhs / g) * longint'(t0)) % s;
    h.offset = lcl_pkg::WORD_W'(qq);
    return h;
  endfunction

  always_ff @(posedge clk) begin
    hit_t e, got;
    if (!rst_n) begin
      wheel <= lcl_pkg::WORD_W'(1);
      hits_due.delete();
      fail_count <= 0;
      solved_count <= 0;
      miss_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == WHEEL_ADDR)
        wheel <= cfg_pwdata[lcl_pkg::WORD_W-1:0];
      if (in_tvalid && in_tready)
        hits_due.insert(hits_due.size(), solve_lane(wheel, in_tdata[30:0],
                                                    in_tdata[61:31], in_tdata[125:62]));
      if (out_tvalid && out_tready) begin
        got.offset = out_tdata[30:0];
        got.step = out_tdata[61:31];
        if (hits_due.size() == 0) begin
          $error("result beat with nothing expected: step %0d offset %0d",
                 got.step, got.offset);
          fail_count <= fail_count + 1;
        end else begin
          e = hits_due.pop_front();
          if (e.step != 0) solved_count <= solved_count + 1;
          else miss_count <= miss_count + 1;
          if (e.step != got.step) begin
            $error("hit_step expected %0d actual %0d", e.step, got.step);
            fail_count <= fail_count + 1;
          end else if (e.offset != got.offset) begin
            $error("hit_offset expected %0d actual %0d", e.offset, got.offset);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= hits_due.size();
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/linear_congruence_lane_offset_test.sv =====
`default_nettype none
module linear_congruence_lane_offset_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] WHEEL_ADDR = 3'd0;
  localparam int RANDOM_ITEMS = 1330;
  localparam longint CYCLE_LIMIT = 25000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [63:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;
  int fail_count, pending, solved_count, miss_count;
  bit calm = 0;
  bit hold_sink = 0;
  longint cycles = 0;
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  linear_congruence_lane_offset dut (.*);

  lane_offset_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sink: random stall bursts, one long hold-off
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 0;
        for (n = 0; n < 3000; n++) @(posedge clk);
        hold_sink = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic write_wheel(logic [30:0] w);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= WHEEL_ADDR; cfg_pwdata <= {1'b0, w};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send_filter(logic [30:0] m, logic [30:0] r, logic [63:0] f);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, f, r, m};
    @(posedge clk iff in_tready);
    sent++;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [30:0] pick31;
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 40));
      1: return 31'($urandom_range(1, 2000));
      2: return 31'h7fffffff - 31'($urandom_range(0, 5));
      3: return 31'(1) << $urandom_range(0, 30);
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    logic [30:0] w, m, r;
    logic [63:0] f;
    logic [30:0] wheels [6] = '{31'd1, 31'd0, 31'd30, 31'h7fffffff, 31'd2310, 31'd510510};
    int i, ph;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset wheel of one
    send_filter(31'd7, 31'd3, 64'd10);
    send_filter(31'd1, 31'd0, 64'd0);
    send_filter(31'd0, 31'd5, 64'd9);
    send_filter(31'h7fffffff, 31'h7ffffffe, 64'hffffffffffffffff);
    drain();
    write_wheel(31'd30);
    send_filter(31'd12, 31'd5, 64'd0);
    send_filter(31'd12, 31'd6, 64'd0);
    send_filter(31'd7, 31'd9, 64'd3);
    send_filter(31'd5, 31'd0, 64'd5);
    send_filter(31'h7fffffff, 31'h7fffffff, 64'h8000000000000000);
    send_filter(31'd0, 31'd0, 64'd0);
    drain();
    write_wheel(31'd0);
    send_filter(31'd9, 31'd4, 64'd4);
    send_filter(31'd9, 31'd4, 64'd5);
    send_filter(31'd0, 31'd1, 64'd1);
    drain();
    write_wheel(31'h7fffffff);
    send_filter(31'h7fffffff, 31'd0, 64'd0);
    send_filter(31'd3, 31'd2, 64'h5555555555555555);
    send_filter(31'h40000000, 31'h2aaaaaaa, 64'haaaaaaaaaaaaaaaa);
    drain();
    for (ph = 0; ph < 10; ph++) begin
      w = (ph < 6) ? wheels[ph] : pick31();
      write_wheel(w);
      if (ph == 9) calm = 1;
      for (i = 0; i < RANDOM_ITEMS / 10; i++) begin
        if (ph == 2 && i == 5) hold_sink = 1;
        m = pick31();
        if ($urandom_range(0, 9) == 0) m = 0;
        r = ($urandom_range(0, 9) == 0 || m == 0) ? pick31() : 31'($urandom % m);
        f = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) f = 64'($urandom_range(0, 100));
        if ($urandom_range(0, 2) == 0 && w != 0 && m != 0)
          f = (64'(r) + 64'(m) - 64'((64'(w) * $urandom_range(0, 50)) % m)) % m;
        send_filter(m, r, f);
      end
      drain();
    end
    $display("Sent %0d filter beats over 14 wheel settings; %0d solvable, %0d never hit.",
             sent, solved_count, miss_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/lcl_pkg.sv
sv/lcl_div.sv
sv/lcl_dp.sv
sv/lcl_ctrl.sv
sv/linear_congruence_lane_offset.sv
tb/sv/lane_offset_checker.sv
tb/sv/linear_congruence_lane_offset_test.sv
